// ----- hdl/tpc_pkg.sv -----
// Shared constants, types and the divider step for the touch calibration block.
package tpc_pkg;

    localparam int ADC_W    = 10;   // converter reading and screen coordinate width
    localparam int SPAN_W   = 10;   // magnitude of a calibration span or of a reading offset
    localparam int PROD_W   = 20;   // magnitude of the scaled reading offset
    localparam int REM_W    = SPAN_W + 1;
    localparam int RES_W    = 24;   // signed working width after the divide
    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int N_CELLS  = PROD_W;

    localparam int DEF_SCREEN_WIDTH  = 480;
    localparam int DEF_SCREEN_HEIGHT = 272;
    localparam int DEF_ADC_BITS      = 10;
    localparam int EDGE_MARGIN       = 10;
    localparam int EDGE_OFFSET       = 5;

    localparam logic [ADC_W-1:0] RST_CAL_X_FIRST  = ADC_W'(848);
    localparam logic [ADC_W-1:0] RST_CAL_Y_FIRST  = ADC_W'(656);
    localparam logic [ADC_W-1:0] RST_CAL_X_SECOND = ADC_W'(186);
    localparam logic [ADC_W-1:0] RST_CAL_Y_SECOND = ADC_W'(349);
    localparam logic             RST_CAL_MODE     = 1'b1;

    typedef enum logic [2:0] {
        REG_CAL_X_FIRST  = 3'd0,
        REG_CAL_Y_FIRST  = 3'd1,
        REG_CAL_X_SECOND = 3'd2,
        REG_CAL_Y_SECOND = 3'd3,
        REG_CAL_MODE     = 3'd4
    } t_reg_idx;

    typedef struct packed {
        logic [ADC_W-1:0] cal_x_first;
        logic [ADC_W-1:0] cal_y_first;
        logic [ADC_W-1:0] cal_x_second;
        logic [ADC_W-1:0] cal_y_second;
        logic             mode;
    } t_cfg;

    // span magnitudes and signs; the user must keep them stable while items are in flight
    typedef struct packed {
        logic              sx;
        logic              sy;
        logic [SPAN_W-1:0] dx;
        logic [SPAN_W-1:0] dy;
    } t_div;

    typedef struct packed {
        logic              neg;
        logic [REM_W-1:0]  rem;
        logic [PROD_W-1:0] acc;   // dividend bits shift out, quotient bits shift in
    } t_axis;

    typedef struct packed {
        logic             pen_up;
        logic [ADC_W-1:0] ax;
        logic [ADC_W-1:0] ay;
        t_axis            x;
        t_axis            y;
    } t_item;

    typedef struct packed {
        logic             pressed;
        logic [ADC_W-1:0] screen_x;
        logic [ADC_W-1:0] screen_y;
        logic             span_error;
    } t_result;

    // One restoring-division step: one quotient bit.
    function automatic t_axis div_step(t_axis a, logic [SPAN_W-1:0] d);
        t_axis            r;
        logic [REM_W-1:0] sh;
        logic [REM_W-1:0] dd;
        r  = a;
        sh = {a.rem[REM_W-2:0], a.acc[PROD_W-1]};
        dd = {1'b0, d};
        if (sh >= dd) begin
            r.rem = sh - dd;
            r.acc = {a.acc[PROD_W-2:0], 1'b1};
        end else begin
            r.rem = sh;
            r.acc = {a.acc[PROD_W-2:0], 1'b0};
        end
        return r;
    endfunction

endpackage

// ----- hdl/tpc_if.sv -----
// Valid/ready channel interfaces for pen events and calibrated results.
interface tpc_in_if;
    logic                       valid;
    logic                       ready;
    logic                       pen_up;
    logic [tpc_pkg::ADC_W-1:0]  adc_x;
    logic [tpc_pkg::ADC_W-1:0]  adc_y;

    modport source (output valid, output pen_up, output adc_x, output adc_y, input ready);
    modport sink   (input valid, input pen_up, input adc_x, input adc_y, output ready);
endinterface

interface tpc_out_if;
    logic                       valid;
    logic                       ready;
    logic                       pressed;
    logic [tpc_pkg::ADC_W-1:0]  screen_x;
    logic [tpc_pkg::ADC_W-1:0]  screen_y;
    logic                       span_error;

    modport source (output valid, output pressed, output screen_x, output screen_y,
                    output span_error, input ready);
    modport sink   (input valid, input pressed, input screen_x, input screen_y,
                    input span_error, output ready);
endinterface

// ----- hdl/tpc_pre.sv -----
// Front stage: mask readings, take offsets from the calibration base and scale them.
module tpc_pre #(
    parameter int SCREEN_WIDTH  = tpc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tpc_pkg::DEF_SCREEN_HEIGHT,
    parameter int ADC_BITS      = tpc_pkg::DEF_ADC_BITS
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  tpc_pkg::t_cfg             i_cfg,
    input  tpc_pkg::t_div             i_div,
    input  logic                      i_valid,
    input  logic                      i_pen_up,
    input  logic [tpc_pkg::ADC_W-1:0] i_adc_x,
    input  logic [tpc_pkg::ADC_W-1:0] i_adc_y,
    output logic                      o_ready,
    output logic                      o_valid,
    output tpc_pkg::t_item            o_item,
    input  logic                      i_ready_next
);
    localparam int ADC_EFF = (ADC_BITS < tpc_pkg::ADC_W) ? ADC_BITS : tpc_pkg::ADC_W;
    localparam logic [tpc_pkg::ADC_W-1:0] ADC_MASK = tpc_pkg::ADC_W'((1 << ADC_EFF) - 1);
    localparam logic [tpc_pkg::SPAN_W-1:0] LEN_X =
        tpc_pkg::SPAN_W'(SCREEN_WIDTH - tpc_pkg::EDGE_MARGIN);
    localparam logic [tpc_pkg::SPAN_W-1:0] LEN_Y =
        tpc_pkg::SPAN_W'(SCREEN_HEIGHT - tpc_pkg::EDGE_MARGIN);

    logic                        r_valid;
    tpc_pkg::t_item              r_item;
    tpc_pkg::t_item              n_item;
    logic [tpc_pkg::ADC_W-1:0]   ax, ay;
    logic [tpc_pkg::REM_W-1:0]   num_x, num_y;
    logic [tpc_pkg::SPAN_W-1:0]  mag_x, mag_y;
    logic [tpc_pkg::REM_W-1:0]   neg_x, neg_y;

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        ax    = i_adc_x & ADC_MASK;
        ay    = i_adc_y & ADC_MASK;
        num_x = {1'b0, ax} - {1'b0, i_cfg.cal_x_second};
        num_y = {1'b0, ay} - {1'b0, i_cfg.cal_y_first};
        neg_x = -num_x;
        neg_y = -num_y;
        mag_x = num_x[tpc_pkg::REM_W-1] ? neg_x[tpc_pkg::SPAN_W-1:0]
                                        : num_x[tpc_pkg::SPAN_W-1:0];
        mag_y = num_y[tpc_pkg::REM_W-1] ? neg_y[tpc_pkg::SPAN_W-1:0]
                                        : num_y[tpc_pkg::SPAN_W-1:0];
        n_item.pen_up = i_pen_up;
        n_item.ax     = ax;
        n_item.ay     = ay;
        n_item.x.neg  = num_x[tpc_pkg::REM_W-1] ^ i_div.sx;
        n_item.y.neg  = num_y[tpc_pkg::REM_W-1] ^ i_div.sy;
        n_item.x.rem  = '0;
        n_item.y.rem  = '0;
        n_item.x.acc  = tpc_pkg::PROD_W'(mag_x) * tpc_pkg::PROD_W'(LEN_X);
        n_item.y.acc  = tpc_pkg::PROD_W'(mag_y) * tpc_pkg::PROD_W'(LEN_Y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end
endmodule

// ----- hdl/tpc_div_cell.sv -----
// One divider cell: produce one quotient bit for both axes and hand the item on.
module tpc_div_cell (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  tpc_pkg::t_div  i_div,
    input  logic           i_valid,
    input  tpc_pkg::t_item i_item,
    output logic           o_ready,
    output logic           o_valid,
    output tpc_pkg::t_item o_item,
    input  logic           i_ready_next
);
    logic           r_valid;
    tpc_pkg::t_item r_item;
    tpc_pkg::t_item n_item;

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        n_item   = i_item;
        n_item.x = tpc_pkg::div_step(i_item.x, i_div.dx);
        n_item.y = tpc_pkg::div_step(i_item.y, i_div.dy);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= n_item;
        end
    end
endmodule

// ----- hdl/tpc_post.sv -----
// Output stage: sign, offset, mirror and clamp; hold the last coordinates.
module tpc_post #(
    parameter int SCREEN_WIDTH  = tpc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tpc_pkg::DEF_SCREEN_HEIGHT
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  tpc_pkg::t_cfg    i_cfg,
    input  tpc_pkg::t_div    i_div,
    input  logic             i_valid,
    input  tpc_pkg::t_item   i_item,
    output logic             o_ready,
    output logic             o_valid,
    output tpc_pkg::t_result o_res,
    input  logic             i_ready_next
);
    localparam logic signed [tpc_pkg::RES_W-1:0] SW = tpc_pkg::RES_W'(SCREEN_WIDTH);
    localparam logic signed [tpc_pkg::RES_W-1:0] SH = tpc_pkg::RES_W'(SCREEN_HEIGHT);
    localparam logic signed [tpc_pkg::RES_W-1:0] OFS = tpc_pkg::RES_W'(tpc_pkg::EDGE_OFFSET);

    logic                               r_valid;
    tpc_pkg::t_result                   r_res;
    tpc_pkg::t_result                   n_res;
    logic [tpc_pkg::ADC_W-1:0]          r_last_x, r_last_y;
    logic signed [tpc_pkg::RES_W-1:0]   qx, qy, vx, vy;
    logic [tpc_pkg::ADC_W-1:0]          cx, cy;
    logic                               zx, zy;

    assign o_ready = !r_valid || i_ready_next;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_comb begin
        qx = $signed({{(tpc_pkg::RES_W - tpc_pkg::PROD_W){1'b0}}, i_item.x.acc});
        qy = $signed({{(tpc_pkg::RES_W - tpc_pkg::PROD_W){1'b0}}, i_item.y.acc});
        if (i_item.x.neg) qx = -qx;
        if (i_item.y.neg) qy = -qy;
        vx = SW - (qx + OFS);
        vy = qy + OFS;
        // clamp to the visible area
        if (vx < 0)        cx = '0;
        else if (vx >= SW) cx = tpc_pkg::ADC_W'(SCREEN_WIDTH - 1);
        else               cx = vx[tpc_pkg::ADC_W-1:0];
        if (vy < 0)        cy = '0;
        else if (vy >= SH) cy = tpc_pkg::ADC_W'(SCREEN_HEIGHT - 1);
        else               cy = vy[tpc_pkg::ADC_W-1:0];
        zx = (i_div.dx == '0);
        zy = (i_div.dy == '0);

        if (i_item.pen_up) begin
            n_res.pressed    = 1'b0;
            n_res.screen_x   = r_last_x;
            n_res.screen_y   = r_last_y;
            n_res.span_error = 1'b0;
        end else if (i_cfg.mode) begin
            n_res.pressed    = 1'b1;
            n_res.screen_x   = zx ? '0 : cx;
            n_res.screen_y   = zy ? '0 : cy;
            n_res.span_error = zx || zy;
        end else begin
            n_res.pressed    = 1'b1;
            n_res.screen_x   = i_item.ax;
            n_res.screen_y   = i_item.ay;
            n_res.span_error = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= 1'b0;
            r_last_x <= '0;
            r_last_y <= '0;
        end else if (o_ready) begin
            r_valid <= i_valid;
            if (i_valid) begin
                r_last_x <= n_res.screen_x;
                r_last_y <= n_res.screen_y;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_res <= n_res;
        end
    end
endmodule

// ----- hdl/touch_two_point_calibration_top.sv -----
// Top level of the touch-panel two-point calibration pipeline with its register port.
//
// Each input transaction is one pen event: a pen-up flag or a pair of converter readings.
// In calibrated mode a pen-down sample is scaled by the screen span, divided by the
// configured calibration span with truncation toward zero, offset, mirrored on X and
// clamped to the screen; otherwise the masked raw readings pass through. A pen-up event
// reports pressed low with the last coordinates. A zero span in calibrated mode forces
// that axis to 0 and raises span_error. Throughput is one transaction per clock unless
// the output stalls. The pipeline is the front scaling stage, a row of 20 divider cells
// (one quotient bit each, both axes side by side) and the output register. Each stage
// has its own valid bit and takes new data whenever it is empty or its successor moves,
// so bubbles close up while the output is stalled. Registers sit at byte addresses 0, 4,
// 8, 12, 16 (cal_x_first, cal_y_first, cal_x_second, cal_y_second, calibrated_mode); the
// user must write them only while no transaction is in flight, unchecked by the block.
module touch_two_point_calibration_top #(
    parameter int SCREEN_WIDTH  = tpc_pkg::DEF_SCREEN_WIDTH,
    parameter int SCREEN_HEIGHT = tpc_pkg::DEF_SCREEN_HEIGHT,
    parameter int ADC_BITS      = tpc_pkg::DEF_ADC_BITS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    tpc_in_if.sink                     i_in,
    tpc_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [tpc_pkg::ADDR_W-1:0] paddr,
    input  logic [tpc_pkg::DATA_W-1:0] pwdata,
    output logic [tpc_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);
    localparam int NC = tpc_pkg::N_CELLS;

    tpc_pkg::t_cfg     r_cfg;
    tpc_pkg::t_div     div;
    tpc_pkg::t_reg_idx reg_idx;
    tpc_pkg::t_result  res;
    logic [tpc_pkg::REM_W-1:0] den_x, den_y, nden_x, nden_y;

    logic           v   [0:NC];
    logic           rdy [0:NC];
    tpc_pkg::t_item it  [0:NC];

    // ---------------- register port ----------------
    assign pready  = 1'b1;
    assign reg_idx = tpc_pkg::t_reg_idx'(paddr[tpc_pkg::ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cal_x_first  <= tpc_pkg::RST_CAL_X_FIRST;
            r_cfg.cal_y_first  <= tpc_pkg::RST_CAL_Y_FIRST;
            r_cfg.cal_x_second <= tpc_pkg::RST_CAL_X_SECOND;
            r_cfg.cal_y_second <= tpc_pkg::RST_CAL_Y_SECOND;
            r_cfg.mode         <= tpc_pkg::RST_CAL_MODE;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                tpc_pkg::REG_CAL_X_FIRST:  r_cfg.cal_x_first  <= pwdata[tpc_pkg::ADC_W-1:0];
                tpc_pkg::REG_CAL_Y_FIRST:  r_cfg.cal_y_first  <= pwdata[tpc_pkg::ADC_W-1:0];
                tpc_pkg::REG_CAL_X_SECOND: r_cfg.cal_x_second <= pwdata[tpc_pkg::ADC_W-1:0];
                tpc_pkg::REG_CAL_Y_SECOND: r_cfg.cal_y_second <= pwdata[tpc_pkg::ADC_W-1:0];
                tpc_pkg::REG_CAL_MODE:     r_cfg.mode         <= pwdata[0];
                default: ;   // drop writes outside the register map
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            tpc_pkg::REG_CAL_X_FIRST:  prdata = tpc_pkg::DATA_W'(r_cfg.cal_x_first);
            tpc_pkg::REG_CAL_Y_FIRST:  prdata = tpc_pkg::DATA_W'(r_cfg.cal_y_first);
            tpc_pkg::REG_CAL_X_SECOND: prdata = tpc_pkg::DATA_W'(r_cfg.cal_x_second);
            tpc_pkg::REG_CAL_Y_SECOND: prdata = tpc_pkg::DATA_W'(r_cfg.cal_y_second);
            tpc_pkg::REG_CAL_MODE:     prdata = tpc_pkg::DATA_W'(r_cfg.mode);
            default:                   prdata = '0;
        endcase
    end

    // ---------------- calibration spans ----------------
    // Stages all read spans; the user must keep them static while transactions are in flight.
    always_comb begin
        den_x  = {1'b0, r_cfg.cal_x_first}  - {1'b0, r_cfg.cal_x_second};
        den_y  = {1'b0, r_cfg.cal_y_second} - {1'b0, r_cfg.cal_y_first};
        nden_x = -den_x;
        nden_y = -den_y;
        div.sx = den_x[tpc_pkg::REM_W-1];
        div.sy = den_y[tpc_pkg::REM_W-1];
        div.dx = div.sx ? nden_x[tpc_pkg::SPAN_W-1:0] : den_x[tpc_pkg::SPAN_W-1:0];
        div.dy = div.sy ? nden_y[tpc_pkg::SPAN_W-1:0] : den_y[tpc_pkg::SPAN_W-1:0];
    end

    // ---------------- front stage: offset and scale ----------------
    tpc_pre #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .ADC_BITS      (ADC_BITS)
    ) u_pre (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_div        (div),
        .i_valid      (i_in.valid),
        .i_pen_up     (i_in.pen_up),
        .i_adc_x      (i_in.adc_x),
        .i_adc_y      (i_in.adc_y),
        .o_ready      (i_in.ready),
        .o_valid      (v[0]),
        .o_item       (it[0]),
        .i_ready_next (rdy[0])
    );

    // ---------------- divider row: one quotient bit per cell, MSB first ----------------
    for (genvar k = 0; k < NC; k++) begin : g_cell
        tpc_div_cell u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_div        (div),
            .i_valid      (v[k]),
            .i_item       (it[k]),
            .o_ready      (rdy[k]),
            .o_valid      (v[k+1]),
            .o_item       (it[k+1]),
            .i_ready_next (rdy[k+1])
        );
    end

    // ---------------- output stage ----------------
    tpc_post #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_post (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .i_div        (div),
        .i_valid      (v[NC]),
        .i_item       (it[NC]),
        .o_ready      (rdy[NC]),
        .o_valid      (o_out.valid),
        .o_res        (res),
        .i_ready_next (o_out.ready)
    );

    assign o_out.pressed    = res.pressed;
    assign o_out.screen_x   = res.screen_x;
    assign o_out.screen_y   = res.screen_y;
    assign o_out.span_error = res.span_error;
endmodule
